// ===== sv/mews_pkg.sv =====
// shared types, constants and register codes for the minimum-energy window search
package mews_pkg;

  localparam int MAX_HOP_DEF     = 4096;
  localparam int HOPS_DEF        = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int HOP_W    = 13;
  localparam int ADDR_W   = 31;
  localparam int POS_W    = 32;
  localparam int MINE_W   = 45;
  localparam int PADDR_W  = 4;

  localparam logic [HOP_W-1:0]  HOP_RESET = 13'd1024;
  localparam logic [MINE_W-1:0] E45_MAX   = {MINE_W{1'b1}};

  localparam logic [1:0] REG_HOP_SIZE      = 2'd0;
  localparam logic [1:0] REG_WINDOW_BEGIN  = 2'd1;
  localparam logic [1:0] REG_REGION_LENGTH = 2'd2;

  typedef struct packed {
    logic [HOP_W-1:0]  hop_size;
    logic [ADDR_W-1:0] window_begin;
    logic [ADDR_W-1:0] region_length;
  } cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            last;
  } q_item_t;

endpackage

// ===== sv/mews_cfg.sv =====
// apb register file: hop size, window begin, region length
module mews_cfg
  import mews_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [HOP_W-1:0]  hop_r, hop_nxt;
  logic [ADDR_W-1:0] begin_r, begin_nxt;
  logic [ADDR_W-1:0] region_r, region_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    hop_nxt    = hop_r;
    begin_nxt  = begin_r;
    region_nxt = region_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_HOP_SIZE:      hop_nxt    = pwdata[HOP_W-1:0];
        REG_WINDOW_BEGIN:  begin_nxt  = pwdata[ADDR_W-1:0];
        REG_REGION_LENGTH: region_nxt = pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HOP_SIZE:      prdata = 32'(hop_r);
      REG_WINDOW_BEGIN:  prdata = 32'(begin_r);
      REG_REGION_LENGTH: prdata = 32'(region_r);
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r    <= HOP_RESET;
      begin_r  <= '0;
      region_r <= '0;
    end else begin
      hop_r    <= hop_nxt;
      begin_r  <= begin_nxt;
      region_r <= region_nxt;
    end
  end

  assign cfg.hop_size      = hop_r;
  assign cfg.window_begin  = begin_r;
  assign cfg.region_length = region_r;

endmodule

// ===== sv/mews_front.sv =====
// front stage: takes input words, squares the sample and tags the last word
module mews_front
  import mews_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       push_valid,
  input  logic                       push_ready,
  output q_item_t                    push_item
);

  logic               v_r, v_nxt;
  q_item_t            item_r;
  logic signed [31:0] prod;
  logic               take;

  assign prod       = in_sample * in_sample;
  assign in_ready   = !v_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = v_r;
  assign push_item  = item_r;

  always_comb begin
    v_nxt = v_r;
    if (take) begin
      v_nxt = 1'b1;
    end else if (push_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.sq   <= prod[SQ_W-1:0];
      item_r.last <= in_last;
    end
  end

endmodule

// ===== sv/mews_fifo.sv =====
// short queue between the front stage and the energy pipeline
module mews_fifo
  import mews_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

endmodule

// ===== sv/mews_back.sv =====
// energy pipeline: hop accumulation, window sum, best-window tracking, result register
module mews_back
  import mews_pkg::*;
#(
  parameter int MAX_HOP         = MAX_HOP_DEF,
  parameter int HOPS_PER_WINDOW = HOPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  q_item_t           pop_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_min_position,
  output logic [MINE_W-1:0] out_min_energy,
  output logic              out_found
);

  localparam int KEEP = HOPS_PER_WINDOW - 1;
  localparam int HW   = $clog2(MAX_HOP + 1);
  localparam int CW   = $clog2(MAX_HOP);
  localparam int EW   = 30 + HW;
  localparam int HCW  = $clog2(HOPS_PER_WINDOW);
  localparam int SPW  = HW + 4;
  localparam int SW   = EW + $clog2(HOPS_PER_WINDOW);
  localparam int SUMW = (SW > MINE_W + 1) ? SW : MINE_W + 1;

  // pipeline advances whenever the result register is free or being drained
  logic en;
  assign en        = !out_valid || out_ready;
  assign pop_ready = en;

  logic pop;
  assign pop = pop_valid && en;

  // effective hop and judging span
  logic [31:0]    hop32;
  logic [HW-1:0]  hop_eff;
  logic [SPW-1:0] span;

  always_comb begin
    hop32 = 32'(cfg.hop_size);
    if (hop32 == 32'd0) begin
      hop_eff = HW'(1);
    end else if (hop32 > 32'(MAX_HOP)) begin
      hop_eff = HW'(MAX_HOP);
    end else begin
      hop_eff = hop32[HW-1:0];
    end
    span = SPW'(HOPS_PER_WINDOW + 1) * SPW'(hop_eff);
  end

  // ---------------- stage 1: hop accumulation ----------------
  logic [EW-1:0]    part_r, part_nxt;
  logic [CW-1:0]    sih_r, sih_nxt;
  logic [HCW-1:0]   hops_r, hops_nxt;
  logic [POS_W-1:0] off_r, off_nxt;
  logic [EW-1:0]    hist_r [KEEP];
  logic [EW-1:0]    hist_nxt [KEEP];

  logic [EW-1:0]    psum;
  logic [HW-1:0]    cnt;
  logic             fin, full, elig, judge;
  logic [32:0]      osum;

  always_comb begin
    psum = part_r + EW'(pop_item.sq);
    cnt  = HW'(sih_r) + HW'(1);
    fin  = cnt >= hop_eff;
    full = hops_r == HCW'(KEEP);
    elig = ({1'b0, off_r} + 33'(span)) < 33'(cfg.region_length);
    judge = fin && full && elig;
    osum = {1'b0, off_r} + 33'(hop_eff);

    part_nxt = part_r;
    sih_nxt  = sih_r;
    hops_nxt = hops_r;
    off_nxt  = off_r;
    for (int i = 0; i < KEEP; i++) begin
      hist_nxt[i] = hist_r[i];
    end

    if (pop) begin
      if (fin) begin
        if (full) begin
          off_nxt = osum[32] ? '1 : osum[31:0];
        end else begin
          hops_nxt = hops_r + HCW'(1);
        end
        for (int i = 0; i < KEEP - 1; i++) begin
          hist_nxt[i] = hist_r[i + 1];
        end
        hist_nxt[KEEP-1] = psum;
        part_nxt = '0;
        sih_nxt  = '0;
      end else begin
        part_nxt = psum;
        sih_nxt  = cnt[CW-1:0];
      end
      // stream ends: start over for the next one
      if (pop_item.last) begin
        part_nxt = '0;
        sih_nxt  = '0;
        hops_nxt = '0;
        off_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      sih_r  <= '0;
      hops_r <= '0;
      off_r  <= '0;
    end else begin
      part_r <= part_nxt;
      sih_r  <= sih_nxt;
      hops_r <= hops_nxt;
      off_r  <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KEEP; i++) begin
      hist_r[i] <= hist_nxt[i];
    end
  end

  logic             b1_v_r;
  logic             b1_judge_r, b1_last_r;
  logic [EW-1:0]    b1_e_r;
  logic [EW-1:0]    b1_hist_r [KEEP];
  logic [POS_W-1:0] b1_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_judge_r <= judge;
      b1_last_r  <= pop_item.last;
      b1_e_r     <= psum;
      b1_off_r   <= off_r;
      for (int i = 0; i < KEEP; i++) begin
        b1_hist_r[i] <= hist_r[i];
      end
    end
  end

  // ---------------- stage 2: window energy ----------------
  logic [SUMW-1:0]   wsum;
  logic [MINE_W-1:0] wsat;
  logic [POS_W-1:0]  wpos;

  always_comb begin
    wsum = SUMW'(b1_e_r);
    for (int i = 0; i < KEEP; i++) begin
      wsum = wsum + SUMW'(b1_hist_r[i]);
    end
    wsat = (wsum > SUMW'(E45_MAX)) ? E45_MAX : wsum[MINE_W-1:0];
    // relative start; window begin is added when the result is formed
    wpos = b1_off_r;
  end

  logic              b2_v_r;
  logic              b2_judge_r, b2_last_r;
  logic [MINE_W-1:0] b2_sum_r;
  logic [POS_W-1:0]  b2_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (en) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && b1_v_r) begin
      b2_judge_r <= b1_judge_r;
      b2_last_r  <= b1_last_r;
      b2_sum_r   <= wsat;
      b2_pos_r   <= wpos;
    end
  end

  // ---------------- stage 3: best window and result ----------------
  logic              best_v_r, best_v_nxt;
  logic [MINE_W-1:0] best_e_r;
  logic [POS_W-1:0]  best_pos_r;
  logic              upd;
  logic              nb_v;
  logic [MINE_W-1:0] nb_e;
  logic [POS_W-1:0]  nb_pos;
  logic              step3, emit;
  logic              oval_r, oval_nxt;
  logic [POS_W-1:0]  opos_r;
  logic [MINE_W-1:0] oe_r;
  logic              ofound_r;

  // strict compare keeps the earliest window on ties
  assign upd    = b2_judge_r && (!best_v_r || (b2_sum_r < best_e_r));
  assign nb_v   = best_v_r || upd;
  assign nb_e   = upd ? b2_sum_r : best_e_r;
  assign nb_pos = upd ? b2_pos_r : best_pos_r;
  assign step3  = en && b2_v_r;
  assign emit   = step3 && b2_last_r;

  always_comb begin
    best_v_nxt = best_v_r;
    if (step3) begin
      best_v_nxt = emit ? 1'b0 : nb_v;
    end
    oval_nxt = oval_r;
    if (emit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      best_v_r <= best_v_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step3 && !b2_last_r) begin
      best_e_r   <= nb_e;
      best_pos_r <= nb_pos;
    end
    if (emit) begin
      opos_r   <= nb_v ? POS_W'(cfg.window_begin) + nb_pos : '0;
      oe_r     <= nb_v ? nb_e : '0;
      ofound_r <= nb_v;
    end
  end

  assign out_valid        = oval_r;
  assign out_min_position = opos_r;
  assign out_min_energy   = oe_r;
  assign out_found        = ofound_r;

endmodule

// ===== sv/min_energy_window_search_core.sv =====
// top level: minimum-energy window search over a sample stream
// throughput: one word per cycle while no result waits; square and hop accumulate run each cycle
// result path: the word marked last passes the front register, the queue, the hop accumulate,
// the window sum and the best-window compare into the result register
// a waiting result stalls the energy pipeline only; the queue keeps taking words until full
// reset: synchronous active-low rst_n clears all stream state; registers return to defaults
module min_energy_window_search_core
  import mews_pkg::*;
#(
  parameter int MAX_HOP         = MAX_HOP_DEF,
  parameter int HOPS_PER_WINDOW = HOPS_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [POS_W-1:0]           out_min_position,
  output logic [MINE_W-1:0]          out_min_energy,
  output logic                       out_found,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  cfg_t    cfg;
  logic    push_valid, push_ready;
  q_item_t push_item;
  logic    pop_valid, pop_ready;
  q_item_t pop_item;

  mews_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mews_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  mews_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  mews_back #(
    .MAX_HOP         (MAX_HOP),
    .HOPS_PER_WINDOW (HOPS_PER_WINDOW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_min_position (out_min_position),
    .out_min_energy   (out_min_energy),
    .out_found        (out_found)
  );

endmodule
